// ----- src/cmvs_pkg.sv -----
// cmvs_pkg: shared types and constants for the complex matrix-vector accumulator
// used by every module of complex_matvec_sum_four_core; no dependencies
`timescale 1ns / 1ps

package cmvs_pkg;

  localparam int FIELD_W            = 32;
  localparam int ACC_W              = 48;
  localparam int PROD_W             = 2 * FIELD_W;
  localparam int NUM_ROWS           = 3;
  localparam int NUM_DIRS           = 4;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH        = 2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m0_re;
    logic signed [FIELD_W-1:0] m0_im;
    logic signed [FIELD_W-1:0] m1_re;
    logic signed [FIELD_W-1:0] m1_im;
    logic signed [FIELD_W-1:0] m2_re;
    logic signed [FIELD_W-1:0] m2_im;
    logic signed [FIELD_W-1:0] vec_re;
    logic signed [FIELD_W-1:0] vec_im;
    logic                      last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out0_re;
    logic signed [FIELD_W-1:0] out0_im;
    logic signed [FIELD_W-1:0] out1_re;
    logic signed [FIELD_W-1:0] out1_im;
    logic signed [FIELD_W-1:0] out2_re;
    logic signed [FIELD_W-1:0] out2_im;
  } out_item_t;

endpackage

// ----- src/cmvs_front.sv -----
// cmvs_front: input register that takes beats and sign-extends data fields
// from DATA_WIDTH bits; depends on cmvs_pkg
`timescale 1ns / 1ps

module cmvs_front import cmvs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output in_item_t push_data
);

  localparam int SH = FIELD_W - DATA_WIDTH;

  function automatic logic signed [FIELD_W-1:0] narrow(input logic signed [FIELD_W-1:0] x);
    logic signed [FIELD_W-1:0] t;
    t = x <<< SH;
    return t >>> SH;
  endfunction

  logic     valid;
  logic     accept;
  in_item_t item;

  assign in_stall  = valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid && !q_full;
  assign push_data = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.m0_re     <= narrow(in_data.m0_re);
      item.m0_im     <= narrow(in_data.m0_im);
      item.m1_re     <= narrow(in_data.m1_re);
      item.m1_im     <= narrow(in_data.m1_im);
      item.m2_re     <= narrow(in_data.m2_re);
      item.m2_im     <= narrow(in_data.m2_im);
      item.vec_re    <= narrow(in_data.vec_re);
      item.vec_im    <= narrow(in_data.vec_im);
      item.last_term <= in_data.last_term;
    end
  end

endmodule

// ----- src/cmvs_queue.sv -----
// cmvs_queue: short fifo between the front register and the arithmetic back end
// depends on cmvs_pkg
`timescale 1ns / 1ps

module cmvs_queue import cmvs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output in_item_t q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  in_item_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue read while empty");

endmodule

// ----- src/cmvs_back.sv -----
// cmvs_back: product stage, saturating row accumulators and output register
// depends on cmvs_pkg
`timescale 1ns / 1ps

module cmvs_back import cmvs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  in_item_t  q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SUM_W = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) <<< (DATA_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PROD_W-1:0] t,
                                                      input logic sub);
    logic signed [SUM_W-1:0] s;
    s = sub ? (SUM_W'(acc) - SUM_W'(t)) : (SUM_W'(acc) + SUM_W'(t));
    if (s > ACC_MAX) begin
      return ACC_MAX[ACC_W-1:0];
    end else if (s < ACC_MIN) begin
      return ACC_MIN[ACC_W-1:0];
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
    if (a > OUT_MAX) begin
      return OUT_MAX[FIELD_W-1:0];
    end else if (a < OUT_MIN) begin
      return OUT_MIN[FIELD_W-1:0];
    end
    return a[FIELD_W-1:0];
  endfunction

  logic                     advance;
  logic                     m_valid;
  logic                     m_last;
  // per row: re*re, im*im, re*im, im*re, already shifted down
  logic signed [PROD_W-1:0] prod [NUM_ROWS][4];
  logic signed [ACC_W-1:0]  acc_re [NUM_ROWS];
  logic signed [ACC_W-1:0]  acc_im [NUM_ROWS];
  logic signed [ACC_W-1:0]  acc_re_next [NUM_ROWS];
  logic signed [ACC_W-1:0]  acc_im_next [NUM_ROWS];
  logic signed [FIELD_W-1:0] a_re [NUM_ROWS];
  logic signed [FIELD_W-1:0] a_im [NUM_ROWS];
  logic signed [FIELD_W-1:0] b_re;
  logic signed [FIELD_W-1:0] b_im;
  logic                     fire;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && q_valid;
  assign fire    = advance && m_valid;

  assign a_re[0] = q_data.m0_re;
  assign a_im[0] = q_data.m0_im;
  assign a_re[1] = q_data.m1_re;
  assign a_im[1] = q_data.m1_im;
  assign a_re[2] = q_data.m2_re;
  assign a_im[2] = q_data.m2_im;
  assign b_re    = q_data.vec_re;
  assign b_im    = q_data.vec_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_last <= q_data.last_term;
      for (int r = 0; r < NUM_ROWS; r++) begin
        prod[r][0] <= (PROD_W'(a_re[r]) * PROD_W'(b_re)) >>> FRAC_BITS;
        prod[r][1] <= (PROD_W'(a_im[r]) * PROD_W'(b_im)) >>> FRAC_BITS;
        prod[r][2] <= (PROD_W'(a_re[r]) * PROD_W'(b_im)) >>> FRAC_BITS;
        prod[r][3] <= (PROD_W'(a_im[r]) * PROD_W'(b_re)) >>> FRAC_BITS;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc_re_next[r] = sat_add(sat_add(acc_re[r], prod[r][0], 1'b0), prod[r][1], 1'b1);
      acc_im_next[r] = sat_add(sat_add(acc_im[r], prod[r][2], 1'b0), prod[r][3], 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc_re[r] <= '0;
        acc_im[r] <= '0;
      end
    end else if (fire) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc_re[r] <= m_last ? '0 : acc_re_next[r];
        acc_im[r] <= m_last ? '0 : acc_im_next[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= m_valid && m_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && m_last) begin
      out_data.out0_re <= sat_out(acc_re_next[0]);
      out_data.out0_im <= sat_out(acc_im_next[0]);
      out_data.out1_re <= sat_out(acc_re_next[1]);
      out_data.out1_im <= sat_out(acc_im_next[1]);
      out_data.out2_re <= sat_out(acc_re_next[2]);
      out_data.out2_im <= sat_out(acc_im_next[2]);
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && m_last) |=> out_valid)
    else $error("last beat did not produce a result");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && m_last) |=> (acc_re[0] == '0 && acc_im[0] == '0))
    else $error("accumulators not cleared after last beat");

endmodule

// ----- src/complex_matvec_sum_four_core.sv -----
// complex_matvec_sum_four_core: top level of the complex three-row matrix-vector accumulator
// depends on cmvs_pkg, cmvs_front, cmvs_queue, cmvs_back
//
// usage
//   in channel: one beat per matrix column, carrying the three complex entries,
//   the matching complex vector element and last_term. every beat is added into
//   six saturating 48-bit accumulators (re and im of three rows).
//   out channel: one beat per beat with last_term set, holding the three rows
//   saturated to DATA_WIDTH bits and sign-extended; the accumulators then clear.
//   throughput: one in beat per cycle, sustained, while the out side keeps up.
//   path: a last_term beat is taken into the front register, then passes the fifo,
//   the product stage and the accumulate/output register, which shows the result.
//   stall on the out side holds the result and freezes the product and
//   accumulate stages; the front register and the 2-entry fifo keep taking
//   beats until they fill, then in_stall rises.
//   reset: synchronous, clears all valid flags, the fifo and the accumulators.
`timescale 1ns / 1ps

module complex_matvec_sum_four_core import cmvs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_full;
  logic     push;
  in_item_t push_data;
  logic     pop;
  logic     q_valid;
  in_item_t q_data;

  cmvs_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  cmvs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  cmvs_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
